// ===== rtl/fir_pkg.sv =====
// Shared types and constants for the streaming FIR filter.
`default_nettype none
package fir_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int COEF_BITS    = 16;
    localparam int TAP_IDX_BITS = 6;
    localparam int FRAC_BITS    = 15;
    localparam int TAPS_DEFAULT = 64;

    typedef enum logic {
        MODE_FILTER = 1'b0,
        MODE_LOAD   = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode                          mode;
        logic signed [SAMPLE_BITS-1:0]  sample;
        logic [TAP_IDX_BITS-1:0]        tap_index;
        logic signed [COEF_BITS-1:0]    tap_value;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0]  filtered;
        logic                           clipped;
    } t_out_beat;

    typedef struct packed {
        logic shift;
        logic clear;
        logic load;
    } t_cell_ctrl;

endpackage
`default_nettype wire

// ===== rtl/fir_cell.sv =====
// One tap cell of the transposed FIR chain: coefficient, multiplier and partial sum.
`default_nettype none
module fir_cell import fir_pkg::*; #(
    parameter int ACC_W = SAMPLE_BITS + COEF_BITS + 7
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_cell_ctrl                 i_ctrl,
    input  wire logic signed [COEF_BITS-1:0]   i_coef,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic signed [ACC_W-1:0]       i_sum,
    output logic signed [ACC_W-1:0]            o_sum
);

    logic signed [COEF_BITS-1:0]              r_coef;
    logic signed [ACC_W-1:0]                  r_sum;
    logic signed [COEF_BITS+SAMPLE_BITS-1:0]  w_prod;
    logic signed [ACC_W-1:0]                  n_sum;

    assign w_prod = r_coef * i_sample;
    assign n_sum  = ACC_W'(w_prod) + i_sum;
    assign o_sum  = r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
            r_sum  <= '0;
        end else begin
            if (i_ctrl.load) begin
                r_coef <= i_coef;
            end
            if (i_ctrl.clear) begin
                r_sum <= '0;
            end else if (i_ctrl.shift) begin
                r_sum <= n_sum;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/fir_sat.sv =====
// Round, scale and saturate the full-precision sum to one output beat.
`default_nettype none
module fir_sat import fir_pkg::*; #(
    parameter int ACC_W = SAMPLE_BITS + COEF_BITS + 7
) (
    input  wire logic signed [ACC_W-1:0] i_sum,
    output t_out_beat                    o_beat
);

    localparam int Q_W = ACC_W + 1 - FRAC_BITS;
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [Q_W-1:0] Q_MIN = ~Q_MAX;

    logic signed [ACC_W:0]  w_round;
    logic signed [Q_W-1:0]  w_q;

    assign w_round = {i_sum[ACC_W-1], i_sum} + (ACC_W+1)'(1 << (FRAC_BITS - 1));
    assign w_q     = w_round[ACC_W:FRAC_BITS];

    always_comb begin
        if (w_q > Q_MAX) begin
            o_beat.filtered = Q_MAX[SAMPLE_BITS-1:0];
            o_beat.clipped  = 1'b1;
        end else if (w_q < Q_MIN) begin
            o_beat.filtered = Q_MIN[SAMPLE_BITS-1:0];
            o_beat.clipped  = 1'b1;
        end else begin
            o_beat.filtered = w_q[SAMPLE_BITS-1:0];
            o_beat.clipped  = 1'b0;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/fir_filter_stream.sv =====
// Top level of the streaming FIR filter: tap cell chain and output pipeline.
//
// Takes one beat per clock cycle unless o_stall is high. A sample beat is
// broadcast to a chain of TAPS cells, each with its own coefficient register
// and one 16 x SAMPLE_BITS multiplier; partial sums move one cell toward the
// output on every sample beat. The full sum lands in the first cell's register,
// is rounded and saturated combinationally, and is captured in the output
// register. A load beat writes at most one coefficient, clears every partial
// sum and gives no output beat. Throughput is one beat per cycle as long as the
// output side does not stall; the cell chain and output register together hold
// two finished results before the input stalls.
`default_nettype none
module fir_filter_stream import fir_pkg::*; #(
    parameter int TAPS = TAPS_DEFAULT
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire t_in_beat   i_data,
    output logic            o_valid,
    input  wire logic       i_stall,
    output t_out_beat       o_data
);

    localparam int ACC_W = SAMPLE_BITS + COEF_BITS + $clog2(TAPS) + 1;

    logic signed [ACC_W-1:0] w_sum [TAPS+1];
    logic                    w_in_acc;
    logic                    w_smp_acc;
    logic                    w_load_acc;
    logic                    w_b_take;
    logic                    r_a_valid;
    logic                    n_a_valid;
    logic                    r_out_valid;
    t_out_beat               r_out_data;
    t_out_beat               w_sat;

    assign w_b_take   = !r_out_valid || !i_stall;
    assign o_stall    = r_a_valid && !w_b_take;
    assign w_in_acc   = i_valid && !o_stall;
    assign w_smp_acc  = w_in_acc && (i_data.mode == MODE_FILTER);
    assign w_load_acc = w_in_acc && (i_data.mode == MODE_LOAD);

    assign w_sum[TAPS] = '0;

    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        localparam bit IN_RANGE = (k < (1 << TAP_IDX_BITS));
        t_cell_ctrl w_ctrl;

        assign w_ctrl.shift = w_smp_acc;
        assign w_ctrl.clear = w_load_acc;
        assign w_ctrl.load  = w_load_acc && IN_RANGE
                              && (i_data.tap_index == TAP_IDX_BITS'(k));

        fir_cell #(
            .ACC_W (ACC_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (w_ctrl),
            .i_coef   (i_data.tap_value),
            .i_sample (i_data.sample),
            .i_sum    (w_sum[k+1]),
            .o_sum    (w_sum[k])
        );
    end

    fir_sat #(
        .ACC_W (ACC_W)
    ) u_sat (
        .i_sum  (w_sum[0]),
        .o_beat (w_sat)
    );

    always_comb begin
        if (w_smp_acc) begin
            n_a_valid = 1'b1;
        end else if (w_b_take) begin
            n_a_valid = 1'b0;
        end else begin
            n_a_valid = r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            if (w_b_take) begin
                r_out_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_take) begin
            r_out_data <= w_sat;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule
`default_nettype wire

// ===== rtl/fir_chk.sv =====
// Port-level checks for the streaming FIR filter, bound to the top level.
`default_nettype none
module fir_chk import fir_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_stall,
    input wire logic      o_valid,
    input wire logic      i_stall,
    input wire t_out_beat o_data
);

    localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled output beat changed");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a blocked output beat");

    a_clip_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.clipped |-> (o_data.filtered == OUT_MAX) ||
                                      (o_data.filtered == OUT_MIN))
        else $error("clipped beat not at a rail");

endmodule

bind fir_filter_stream fir_chk u_fir_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
`default_nettype wire

// ===== test/fir_filter_stream_checker.sv =====
// Beat monitor for the streaming FIR filter: predicts each filtered sample and compares.
module fir_filter_stream_checker import fir_pkg::*; #(
    parameter int TAPS = TAPS_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_beat  i_in_beat,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_beat i_out_beat,
    output int        o_errors,
    output int        o_pending,
    output int        o_checked,
    output int        o_clipped
);

    localparam longint FILTERED_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint FILTERED_MIN = -FILTERED_MAX - 1;
    localparam longint ROUND_HALF   = longint'(1) <<< (FRAC_BITS - 1);

    logic signed [COEF_BITS-1:0]   coef [TAPS];
    logic signed [SAMPLE_BITS-1:0] delay_line [TAPS];
    t_out_beat                     filtered_q [$];
    int                            error_count;
    int                            checked_count;
    int                            clipped_count;

    function automatic t_out_beat filter_sample(input logic signed [SAMPLE_BITS-1:0] x);
        longint    acc;
        longint    rounded;
        t_out_beat res;
        acc = longint'(coef[0]) * longint'(x);
        for (int k = 1; k < TAPS; k++) begin
            acc += longint'(coef[k]) * longint'(delay_line[k-1]);
        end
        for (int k = TAPS - 2; k > 0; k--) begin
            delay_line[k] = delay_line[k-1];
        end
        delay_line[0] = x;
        rounded = (acc + ROUND_HALF) >>> FRAC_BITS;
        res.clipped = 1'b0;
        if (rounded > FILTERED_MAX) begin
            rounded = FILTERED_MAX;
            res.clipped = 1'b1;
        end
        if (rounded < FILTERED_MIN) begin
            rounded = FILTERED_MIN;
            res.clipped = 1'b1;
        end
        res.filtered = rounded[SAMPLE_BITS-1:0];
        return res;
    endfunction

    function automatic void load_coef(input t_in_beat beat);
        if (int'(beat.tap_index) < TAPS) begin
            coef[beat.tap_index] = beat.tap_value;
        end
        foreach (delay_line[k]) delay_line[k] = '0;
    endfunction

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            foreach (coef[k]) coef[k] = '0;
            foreach (delay_line[k]) delay_line[k] = '0;
            filtered_q.delete();
            error_count   = 0;
            checked_count = 0;
            clipped_count = 0;
        end else begin
            // check the output first so a beat can never match its own prediction
            if (i_out_valid && !i_out_stall) begin
                if (filtered_q.size() == 0) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("[%0t] unexpected output beat: filtered=%0d clipped=%0b",
                                 $realtime, i_out_beat.filtered, i_out_beat.clipped);
                    end
                end else begin
                    want = filtered_q.pop_front();
                    checked_count++;
                    if (want.clipped) clipped_count++;
                    if (i_out_beat.filtered !== want.filtered
                            || i_out_beat.clipped !== want.clipped) begin
                        error_count++;
                        if (error_count <= 10) begin
                            $display("[%0t] output beat %0d: expected filtered=%0d clipped=%0b,%s",
                                     $realtime, checked_count, want.filtered, want.clipped,
                                     $sformatf(" got filtered=%0d clipped=%0b",
                                               i_out_beat.filtered, i_out_beat.clipped));
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_beat.mode == MODE_LOAD) begin
                    load_coef(i_in_beat);
                end else begin
                    filtered_q.push_back(filter_sample(i_in_beat.sample));
                end
            end
        end
        o_errors  <= error_count;
        o_pending <= filtered_q.size();
        o_checked <= checked_count;
        o_clipped <= clipped_count;
    end

endmodule

// ===== test/fir_filter_stream_tb.sv =====
// Testbench top for the streaming FIR filter: clock, reset, stimulus and verdict.
module fir_filter_stream_tb;
    import fir_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_BEATS = 265;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_beat  in_beat;
    logic      out_valid;
    logic      out_stall;
    t_out_beat out_beat;

    int errors;
    int pending;
    int checked;
    int clipped;
    int idle_pct;
    int stall_pct;
    int samples_sent;
    int loads_sent;
    int quiet_cycles;

    fir_filter_stream DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_stall (in_stall),
        .i_data  (in_beat),
        .o_valid (out_valid),
        .i_stall (out_stall),
        .o_data  (out_beat)
    );

    fir_filter_stream_checker u_monitor (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_beat  (out_beat),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_clipped   (clipped)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] no beat moved for %0d cycles", $realtime, STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return '0;
            3, 4:    return 16'(int'($urandom_range(4095)) - 2048);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_beat(input t_in_beat beat);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (beat.mode == MODE_LOAD) loads_sent++;
        else samples_sent++;
    endtask

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] x);
        t_in_beat beat;
        beat.mode      = MODE_FILTER;
        beat.sample    = x;
        beat.tap_index = TAP_IDX_BITS'($urandom);
        beat.tap_value = COEF_BITS'($urandom);
        send_beat(beat);
    endtask

    task automatic send_load(input logic [TAP_IDX_BITS-1:0] idx,
                             input logic signed [COEF_BITS-1:0] value);
        t_in_beat beat;
        beat.mode      = MODE_LOAD;
        beat.sample    = SAMPLE_BITS'($urandom);
        beat.tap_index = idx;
        beat.tap_value = value;
        send_beat(beat);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic run_group();
        t_in_beat junk;
        int       loads;
        int       samples;
        if ($urandom_range(9) == 0) begin
            junk.mode      = t_mode'($urandom_range(1));
            junk.sample    = SAMPLE_BITS'($urandom);
            junk.tap_index = TAP_IDX_BITS'($urandom);
            junk.tap_value = COEF_BITS'($urandom);
            send_beat(junk);
        end else begin
            loads   = $urandom_range(4);
            samples = $urandom_range(1, 48);
            repeat (loads) send_load(TAP_IDX_BITS'($urandom), pick_value());
            repeat (samples) send_sample(pick_value());
        end
    endtask

    initial begin
        int idle_plan  [5];
        int stall_plan [5];
        int phase_end;
        idle_plan    = '{0, 72, 0, 27, 0};
        stall_plan   = '{0, 0, 72, 27, 0};
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        in_beat      <= '0;
        out_stall    <= 1'b0;
        quiet_cycles <= 0;
        idle_pct     = 0;
        stall_pct    = 0;
        samples_sent = 0;
        loads_sent   = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty filter, full-scale taps, both saturation signs, rounding at +-1
        send_sample(16'sd1000);
        send_load(6'd0, 16'sh7fff);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_load(6'd0, 16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        send_load(6'd63, 16'sh8000);
        send_load(6'd0, 16'sh7fff);
        send_load(6'd1, 16'sh7fff);
        send_load(6'd2, 16'sh7fff);
        send_load(6'd3, 16'sh7fff);
        repeat (4) send_sample(16'sh7fff);
        repeat (3) send_sample(16'sh8000);
        send_sample(16'sd0);
        send_load(6'd5, 16'sd0);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        drain();

        for (int p = 0; p < 5; p++) begin
            idle_pct  = idle_plan[p];
            stall_pct = stall_plan[p];
            phase_end = samples_sent + loads_sent + PHASE_BEATS;
            while (samples_sent + loads_sent < phase_end) run_group();
            drain();
        end

        stall_pct = 0;
        repeat (8) @(posedge clk);
        $display("Covered %0d sample beats and %0d coefficient loads; %0d results checked, %0d clipped.",
                 samples_sent, loads_sent, checked, clipped);
        $display("Phases: free flow, sender idling, receiver stalling, both idling, free flow.");
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== fir_filter_stream.f =====
rtl/fir_pkg.sv
rtl/fir_cell.sv
rtl/fir_sat.sv
rtl/fir_filter_stream.sv
rtl/fir_chk.sv
test/fir_filter_stream_checker.sv
test/fir_filter_stream_tb.sv
